FILE: design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQEN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SQEN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

// Delayed implication, disabled while reset is asserted.
`define SQEN_ASSERT_LAT2(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error("assertion failed: two-cycle latency");

`endif

FILE: design/sqen_pkg.sv
// Package with widths, register indexes, types and helpers of the quad element node block.
package sqen_pkg;

	localparam int MAX_SIDE   = 1024;
	localparam int SIDE_W     = 11;
	localparam int COORD_W    = 10;
	localparam int ID_W       = 32;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_SLOTS  = 12;
	localparam int SUB_W      = 2;
	localparam int FULL_W     = 12;
	localparam int BLOCK_W    = 13;
	localparam int PROD_W     = 23;
	localparam int OFF_W      = 14;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ELEM_KIND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_BASE = 2'd3;

	// Element kind codes; the two codes not named here both behave as the twelve-node kind.
	localparam logic [KIND_W-1:0] KIND_Q4 = 2'd0;
	localparam logic [KIND_W-1:0] KIND_Q8 = 2'd1;

	typedef logic [ID_W-1:0] node_id_t;
	typedef logic [OFF_W-1:0] node_off_t;
	typedef logic [NUM_SLOTS-1:0][ID_W-1:0] slot_vec_t;

	// Everything the slot stage needs about one element.
	typedef struct packed {
		node_id_t             row_base;
		logic [COORD_W-1:0]   along_elem;
		logic [SUB_W-1:0]     sub;
		logic                 col_major;
		logic                 in_grid;
		logic [FULL_W-1:0]    full_len;
		logic [SIDE_W-1:0]    line_len;
		logic [BLOCK_W-1:0]   block_len;
	} stage_t;

	// Multiply a side-sized value by the edge subdivision (1, 2 or 3) with shifts and adds.
	function automatic logic [BLOCK_W-1:0] times_sub(logic [SIDE_W-1:0] v, logic [SUB_W-1:0] sub);
		logic [BLOCK_W-1:0] w;
		w = BLOCK_W'(v);
		case (sub)
			2'd1: times_sub = w;
			2'd2: times_sub = w << 1;
			2'd3: times_sub = w + (w << 1);
			default: times_sub = '0;
		endcase
	endfunction

endpackage

FILE: design/sqen_if.sv
// Channel interfaces of the quad element node block: element input, node result, configuration.
interface sqen_in_if;
	import sqen_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] elem_col;
	logic [COORD_W-1:0] elem_row;
	modport source(output valid, elem_col, elem_row, input ready);
	modport sink(input valid, elem_col, elem_row, output ready);
endinterface

interface sqen_out_if;
	import sqen_pkg::*;
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] corner_a;
	logic [ID_W-1:0] slot_one;
	logic [ID_W-1:0] slot_two;
	logic [ID_W-1:0] slot_three;
	logic [ID_W-1:0] slot_four;
	logic [ID_W-1:0] slot_five;
	logic [ID_W-1:0] slot_six;
	logic [ID_W-1:0] slot_seven;
	logic [ID_W-1:0] slot_eight;
	logic [ID_W-1:0] slot_nine;
	logic [ID_W-1:0] slot_ten;
	logic [ID_W-1:0] slot_eleven;
	modport source(output valid, corner_a, slot_one, slot_two, slot_three, slot_four,
		slot_five, slot_six, slot_seven, slot_eight, slot_nine, slot_ten, slot_eleven,
		input ready);
	modport sink(input valid, corner_a, slot_one, slot_two, slot_three, slot_four,
		slot_five, slot_six, slot_seven, slot_eight, slot_nine, slot_ten, slot_eleven,
		output ready);
endinterface

interface sqen_cfg_if;
	import sqen_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: design/sqen_slot_calc.sv
// Slot stage: turns one element's row base and offsets into its twelve node id slots.
module sqen_slot_calc (
	input  sqen_pkg::stage_t    stage,
	output sqen_pkg::slot_vec_t slots
);
	import sqen_pkg::*;

	logic [BLOCK_W-1:0]       sub_along;
	node_off_t                off_row0 [4];
	node_off_t                off_row1 [4];
	node_off_t                off_mid1 [2];
	node_off_t                off_mid2 [2];
	node_off_t                off      [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]     slot_en;

	// Offsets of the candidate nodes relative to the lower node line of the element.
	always_comb begin
		sub_along = times_sub(SIDE_W'(stage.along_elem), stage.sub);
		for (int t = 0; t < 4; t++) begin
			off_row0[t] = OFF_W'(sub_along) + OFF_W'(t);
			off_row1[t] = OFF_W'(stage.block_len) + OFF_W'(sub_along) + OFF_W'(t);
		end
		for (int b = 0; b < 2; b++) begin
			off_mid1[b] = OFF_W'(stage.full_len) + OFF_W'(stage.along_elem) + OFF_W'(b);
			off_mid2[b] = OFF_W'(stage.full_len) + OFF_W'(stage.line_len)
				+ OFF_W'(stage.along_elem) + OFF_W'(b);
		end
	end

	// Counter-clockwise ordering from the lower left corner, per subdivision and numbering order.
	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			off[k] = '0;
		end
		slot_en = '0;
		case (stage.sub)
			2'd1: begin
				slot_en[3:0] = '1;
				off[0] = off_row0[0];
				off[1] = stage.col_major ? off_row1[0] : off_row0[1];
				off[2] = off_row1[1];
				off[3] = stage.col_major ? off_row0[1] : off_row1[0];
			end
			2'd2: begin
				slot_en[7:0] = '1;
				if (stage.col_major) begin
					off[0] = off_row0[0]; off[1] = off_mid1[0];
					off[2] = off_row1[0]; off[3] = off_row1[1];
					off[4] = off_row1[2]; off[5] = off_mid1[1];
					off[6] = off_row0[2]; off[7] = off_row0[1];
				end else begin
					off[0] = off_row0[0]; off[1] = off_row0[1];
					off[2] = off_row0[2]; off[3] = off_mid1[1];
					off[4] = off_row1[2]; off[5] = off_row1[1];
					off[6] = off_row1[0]; off[7] = off_mid1[0];
				end
			end
			default: begin
				slot_en = '1;
				if (stage.col_major) begin
					off[0]  = off_row0[0]; off[1]  = off_mid1[0]; off[2]  = off_mid2[0];
					off[3]  = off_row1[0]; off[4]  = off_row1[1]; off[5]  = off_row1[2];
					off[6]  = off_row1[3]; off[7]  = off_mid2[1]; off[8]  = off_mid1[1];
					off[9]  = off_row0[3]; off[10] = off_row0[2]; off[11] = off_row0[1];
				end else begin
					off[0]  = off_row0[0]; off[1]  = off_row0[1]; off[2]  = off_row0[2];
					off[3]  = off_row0[3]; off[4]  = off_mid1[1]; off[5]  = off_mid2[1];
					off[6]  = off_row1[3]; off[7]  = off_row1[2]; off[8]  = off_row1[1];
					off[9]  = off_row1[0]; off[10] = off_mid2[0]; off[11] = off_mid1[0];
				end
			end
		endcase
	end

	// Final id add; unused slots and elements outside the grid read as zero.
	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			slots[k] = (stage.in_grid && slot_en[k])
				? stage.row_base + ID_W'(off[k]) : '0;
		end
	end

endmodule

FILE: design/structured_quad_element_nodes_core.sv
// Top level of the structured quad element node block.
// The block maps an element (column, row) of a structured rectangular grid to the
// global ids of its 4, 8 or 12 boundary nodes, counter-clockwise from the lower left.
// Channels: cfg takes register writes (index, data) and is always ready; item takes one
// element per beat; result gives one beat of twelve 32-bit node ids per element.
// Configuration must be written only while no element is in flight (not enforced).
// An accepted element passes the two register stages (element stage with the row-base
// multiply, then the slot add stage) and leaves from the slot add stage register.
// Throughput: one element per cycle while result.ready is high.
// When result.ready is low the result register holds its beat; one more element
// may still be taken into the element stage, after which item.ready drops.
// Reset clears both stage valid bits and loads the registers with their defaults:
// two by two corner nodes, the four-node kind, and a base id of zero.
module structured_quad_element_nodes_core (
	input  logic clk,
	input  logic arst_n,
	sqen_cfg_if.sink   cfg,
	sqen_in_if.sink    item,
	sqen_out_if.source result
);
	import sqen_pkg::*;

	logic [SIDE_W-1:0]  grid_cols_q;
	logic [SIDE_W-1:0]  grid_rows_q;
	logic [KIND_W-1:0]  elem_kind_q;
	node_id_t           node_base_q;

	logic               col_major;
	logic [SIDE_W-1:0]  line_len;
	logic [COORD_W-1:0] across_elem;
	logic [SUB_W-1:0]   sub;
	logic               side_ok;
	logic [PROD_W-1:0]  row_prod;
	stage_t             stage_d;
	stage_t             stage_s1;
	logic               vld_s1;

	slot_vec_t          slot_d;
	slot_vec_t          slot_s2;
	logic               vld_s2;
	logic               adv_s2;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= SIDE_W'(2);
			grid_rows_q <= SIDE_W'(2);
			elem_kind_q <= KIND_Q4;
			node_base_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GRID_COLS: grid_cols_q <= cfg.data[SIDE_W-1:0];
				REG_GRID_ROWS: grid_rows_q <= cfg.data[SIDE_W-1:0];
				REG_ELEM_KIND: elem_kind_q <= cfg.data[KIND_W-1:0];
				REG_NODE_BASE: node_base_q <= cfg.data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// Element stage: numbering order, line lengths, range check and the row base id.
	always_comb begin
		col_major   = !(grid_cols_q < grid_rows_q);
		line_len    = col_major ? grid_rows_q : grid_cols_q;
		across_elem = col_major ? item.elem_col : item.elem_row;
		if (elem_kind_q == KIND_Q4) begin
			sub = 2'd1;
		end else if (elem_kind_q == KIND_Q8) begin
			sub = 2'd2;
		end else begin
			sub = 2'd3;
		end
		side_ok = (grid_cols_q >= SIDE_W'(2)) && (grid_cols_q <= SIDE_W'(MAX_SIDE))
			&& (grid_rows_q >= SIDE_W'(2)) && (grid_rows_q <= SIDE_W'(MAX_SIDE));

		stage_d.col_major  = col_major;
		stage_d.sub        = sub;
		stage_d.line_len   = line_len;
		stage_d.along_elem = col_major ? item.elem_row : item.elem_col;
		stage_d.in_grid    = side_ok
			&& (SIDE_W'(item.elem_col) < grid_cols_q - SIDE_W'(1))
			&& (SIDE_W'(item.elem_row) < grid_rows_q - SIDE_W'(1));
		stage_d.full_len   = FULL_W'(times_sub(line_len - SIDE_W'(1), sub) + BLOCK_W'(1));
		stage_d.block_len  = BLOCK_W'(stage_d.full_len) + times_sub(line_len, sub - SUB_W'(1));
		row_prod           = PROD_W'(across_elem) * PROD_W'(stage_d.block_len);
		stage_d.row_base   = node_base_q + ID_W'(row_prod);
	end

	// Pipeline handshake: each stage moves when the one after it has room.
	assign adv_s2     = !vld_s2 || result.ready;
	assign item.ready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				vld_s1 <= item.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			stage_s1 <= stage_d;
		end
		if (adv_s2 && vld_s1) begin
			slot_s2 <= slot_d;
		end
	end

	// Slot stage.
	sqen_slot_calc u_slot_calc (
		.stage (stage_s1),
		.slots (slot_d)
	);

	// Result beat.
	assign result.valid       = vld_s2;
	assign result.corner_a    = slot_s2[0];
	assign result.slot_one    = slot_s2[1];
	assign result.slot_two    = slot_s2[2];
	assign result.slot_three  = slot_s2[3];
	assign result.slot_four   = slot_s2[4];
	assign result.slot_five   = slot_s2[5];
	assign result.slot_six    = slot_s2[6];
	assign result.slot_seven  = slot_s2[7];
	assign result.slot_eight  = slot_s2[8];
	assign result.slot_nine   = slot_s2[9];
	assign result.slot_ten    = slot_s2[10];
	assign result.slot_eleven = slot_s2[11];

endmodule

FILE: design/sqen_checker.sv
// Port-level checker of the quad element node block and its bind to the top level.
`include "assert_macros.svh"

module sqen_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] corner_a,
	input logic [31:0] slot_three,
	input logic [31:0] slot_seven,
	input logic [31:0] slot_eleven
);
	logic [1:0] cnt_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Elements accepted whose result beat has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, in_beat} - {1'b0, out_beat};
		end
	end

	// A stalled result beat keeps its payload.
	`SQEN_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(corner_a) && $stable(slot_three) && $stable(slot_seven) && $stable(slot_eleven))

	// No result beat appears without an element in flight.
	`SQEN_ASSERT_IMP(a_no_phantom, clk, arst_n, out_valid, cnt_q != 2'd0)

	// At most two elements are held inside the block.
	`SQEN_ASSERT_IMP(a_depth, clk, arst_n, 1'b1, cnt_q <= 2'd2)

	// An element entering an empty block raises the result valid after both stage registers, with no stall between.
	`SQEN_ASSERT_LAT2(a_latency, clk, arst_n, in_beat && cnt_q == 2'd0, out_valid && !$past(out_valid))

endmodule

bind structured_quad_element_nodes_core sqen_checker u_sqen_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.corner_a    (result.corner_a),
	.slot_three  (result.slot_three),
	.slot_seven  (result.slot_seven),
	.slot_eleven (result.slot_eleven)
);

FILE: tb/sv/structured_quad_element_nodes_core_test.sv
// Self-checking testbench of the structured quad element node block with its own predictor.
module structured_quad_element_nodes_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sqen_pkg::*;

	// Kind codes that the package does not name.
	localparam logic [KIND_W-1:0] KIND_Q12   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} elem_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_LONG_STALL, SINK_TRICKLE} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	sqen_cfg_if cfg_ch();
	sqen_in_if  elem_ch();
	sqen_out_if node_ch();

	structured_quad_element_nodes_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.item(elem_ch),
		.result(node_ch)
	);

	// Register copies seen by the predictor.
	logic [SIDE_W-1:0] cur_cols;
	logic [SIDE_W-1:0] cur_rows;
	logic [KIND_W-1:0] cur_kind;
	node_id_t          cur_base;

	elem_t     pending_elems[$];
	slot_vec_t expected_nodes[$];
	int        error_count = 0;

	// Sender and receiver pacing.
	logic       beat_waiting = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;
	sink_mode_t sink_mode = SINK_OPEN;
	int         mode_left = 0;
	int         stall_left = 0;

	string slot_name [NUM_SLOTS] = '{"corner_a", "slot_one", "slot_two", "slot_three",
		"slot_four", "slot_five", "slot_six", "slot_seven", "slot_eight", "slot_nine",
		"slot_ten", "slot_eleven"};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Id of the fine-grid point (fi, fj) when every edge is split into sub parts.
	function automatic node_id_t grid_point_id(longint unsigned fi, longint unsigned fj,
		longint unsigned sub);
		longint unsigned line_len, along, across, full_len, block_len, q, r, off;
		if (cur_cols < cur_rows) begin
			line_len = 64'(cur_cols);
			along = fi;
			across = fj;
		end else begin
			line_len = 64'(cur_rows);
			along = fj;
			across = fi;
		end
		full_len = sub * (line_len - 1) + 1;
		block_len = full_len + (sub - 1) * line_len;
		q = across / sub;
		r = across % sub;
		if (r == 0)
			off = along;
		else
			off = full_len + (r - 1) * line_len + along / sub;
		return node_id_t'(64'(cur_base) + q * block_len + off);
	endfunction

	// Boundary node ids of one element, counter-clockwise from the lower left corner.
	function automatic slot_vec_t element_nodes(logic [COORD_W-1:0] col,
		logic [COORD_W-1:0] row);
		slot_vec_t ids;
		longint unsigned sub, fi0, fj0, k;
		int slot;
		ids = '0;
		slot = 0;
		if (cur_cols < 2 || cur_rows < 2 || cur_cols > MAX_SIDE || cur_rows > MAX_SIDE)
			return ids;
		if (int'(col) >= int'(cur_cols) - 1 || int'(row) >= int'(cur_rows) - 1)
			return ids;
		sub = (cur_kind == KIND_Q4) ? 64'd1 : ((cur_kind == KIND_Q8) ? 64'd2 : 64'd3);
		fi0 = sub * 64'(col);
		fj0 = sub * 64'(row);
		for (k = 0; k < sub; k++) begin
			ids[slot] = grid_point_id(fi0 + k, fj0, sub);
			slot++;
		end
		for (k = 0; k < sub; k++) begin
			ids[slot] = grid_point_id(fi0 + sub, fj0 + k, sub);
			slot++;
		end
		for (k = 0; k < sub; k++) begin
			ids[slot] = grid_point_id(fi0 + sub - k, fj0 + sub, sub);
			slot++;
		end
		for (k = 0; k < sub; k++) begin
			ids[slot] = grid_point_id(fi0, fj0 + sub - k, sub);
			slot++;
		end
		return ids;
	endfunction

	// Element driver: bursts of beats from the pending queue with random gaps between them.
	always @(negedge clk) begin
		if (!arst_n) begin
			elem_ch.valid <= 1'b0;
		end else if (!beat_waiting) begin
			if (gap_left > 0) begin
				gap_left--;
				elem_ch.valid <= 1'b0;
			end else if (pending_elems.size() > 0) begin
				elem_ch.valid <= 1'b1;
				elem_ch.elem_col <= pending_elems[0].col;
				elem_ch.elem_row <= pending_elems[0].row;
				beat_waiting = 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						gap_left = 0;
						burst_left = $urandom_range(20, 60);
					end else begin
						gap_left = $urandom_range(1, 5);
						burst_left = $urandom_range(1, 8);
					end
				end
			end else begin
				elem_ch.valid <= 1'b0;
			end
		end
	end

	// Accepted element beats turn into expected node sets.
	always @(posedge clk) begin
		if (arst_n && elem_ch.valid && elem_ch.ready) begin
			void'(pending_elems.pop_front());
			expected_nodes.push_back(element_nodes(elem_ch.elem_col, elem_ch.elem_row));
			beat_waiting = 1'b0;
		end
	end

	// Result ready follows a stall pattern that changes every so often.
	always @(negedge clk) begin
		if (!arst_n) begin
			node_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (sink_mode)
				SINK_OPEN: node_ch.ready <= 1'b1;
				SINK_COIN: node_ch.ready <= 1'($urandom_range(0, 1));
				SINK_LONG_STALL: begin
					if (stall_left > 0) begin
						stall_left--;
						node_ch.ready <= 1'b0;
					end else begin
						stall_left = $urandom_range(1, 12);
						node_ch.ready <= 1'b1;
					end
				end
				default: node_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result monitor: every beat is compared slot by slot with the oldest expectation.
	always @(posedge clk) begin : check_nodes
		slot_vec_t got;
		slot_vec_t want;
		if (arst_n && node_ch.valid && node_ch.ready) begin
			got = {node_ch.slot_eleven, node_ch.slot_ten, node_ch.slot_nine,
				node_ch.slot_eight, node_ch.slot_seven, node_ch.slot_six, node_ch.slot_five,
				node_ch.slot_four, node_ch.slot_three, node_ch.slot_two, node_ch.slot_one,
				node_ch.corner_a};
			if (expected_nodes.size() == 0) begin
				error_count++;
				$display("%0t: result beat with nothing expected, actual %h", $realtime, got);
			end else begin
				want = expected_nodes.pop_front();
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (got[k] !== want[k]) begin
						error_count++;
						$display("%0t: %s expected %h actual %h", $realtime, slot_name[k],
							want[k], got[k]);
					end
				end
			end
		end
	end

	// One register write; the predictor copy changes when the beat is accepted.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= word;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_GRID_COLS: cur_cols = word[SIDE_W-1:0];
			REG_GRID_ROWS: cur_rows = word[SIDE_W-1:0];
			REG_ELEM_KIND: cur_kind = word[KIND_W-1:0];
			REG_NODE_BASE: cur_base = word;
			default: ;
		endcase
	endtask

	// Let every element in flight come out before the registers change.
	task automatic wait_idle();
		while (pending_elems.size() != 0 || expected_nodes.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic setup_grid(input logic [CFG_DATA_W-1:0] cols_word,
		input logic [CFG_DATA_W-1:0] rows_word, input logic [CFG_DATA_W-1:0] kind_word,
		input logic [CFG_DATA_W-1:0] base_word);
		wait_idle();
		write_reg(REG_GRID_COLS, cols_word);
		write_reg(REG_GRID_ROWS, rows_word);
		write_reg(REG_ELEM_KIND, kind_word);
		write_reg(REG_NODE_BASE, base_word);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_elem(input int col, input int row);
		elem_t e;
		e.col = COORD_W'(col);
		e.row = COORD_W'(row);
		pending_elems.push_back(e);
	endtask

	// Mostly small grids, some up to the largest side, a few of any register value.
	function automatic logic [CFG_DATA_W-1:0] pick_side_word();
		logic [SIDE_W-1:0] side;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			side = SIDE_W'($urandom_range(0, 2047));
		else if (pick == 1)
			side = SIDE_W'($urandom_range(2, MAX_SIDE));
		else
			side = SIDE_W'($urandom_range(2, 12));
		if ($urandom_range(0, 3) == 0)
			return ($urandom() & ~32'h7FF) | CFG_DATA_W'(side);
		return CFG_DATA_W'(side);
	endfunction

	// One random register setting followed by a batch of elements, most in the grid when its size is legal.
	task automatic random_phase(input int n_items);
		logic [CFG_DATA_W-1:0] kind_word;
		logic [CFG_DATA_W-1:0] base_word;
		logic grid_ok;
		int col, row;
		kind_word = CFG_DATA_W'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			kind_word = ($urandom() & ~32'h3) | kind_word;
		case ($urandom_range(0, 3))
			0: base_word = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			1: base_word = $urandom_range(0, 1000);
			default: base_word = $urandom();
		endcase
		setup_grid(pick_side_word(), pick_side_word(), kind_word, base_word);
		grid_ok = cur_cols >= 2 && cur_rows >= 2 && cur_cols <= MAX_SIDE && cur_rows <= MAX_SIDE;
		for (int i = 0; i < n_items; i++) begin
			if (grid_ok && $urandom_range(0, 6) != 0) begin
				col = $urandom_range(0, int'(cur_cols) - 2);
				row = $urandom_range(0, int'(cur_rows) - 2);
			end else begin
				col = $urandom_range(0, 1023);
				row = $urandom_range(0, 1023);
			end
			queue_elem(col, row);
		end
	endtask

	// Stimulus sequence and end of run.
	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		elem_ch.valid = 1'b0;
		elem_ch.elem_col = '0;
		elem_ch.elem_row = '0;
		node_ch.ready = 1'b0;
		cur_cols = 11'd2;
		cur_rows = 11'd2;
		cur_kind = KIND_Q4;
		cur_base = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset setting: one four-node element, with the field extremes around it.
		queue_elem(0, 0);
		queue_elem(1, 0);
		queue_elem(0, 1);
		queue_elem(1023, 1023);

		// Fewer columns than rows gives row-major numbering.
		setup_grid(3, 5, CFG_DATA_W'(KIND_Q8), 100);
		queue_elem(0, 0);
		queue_elem(1, 3);
		queue_elem(2, 0);

		// More columns than rows gives column-major numbering.
		setup_grid(5, 3, CFG_DATA_W'(KIND_Q12), 0);
		queue_elem(0, 0);
		queue_elem(3, 1);

		// Square grid, the spare kind code, and ids that wrap past the top.
		setup_grid(4, 4, CFG_DATA_W'(KIND_SPARE), 32'hFFFF_FFF0);
		queue_elem(2, 2);
		queue_elem(0, 0);

		// Largest grid with the last element and an element just outside.
		setup_grid(MAX_SIDE, MAX_SIDE, CFG_DATA_W'(KIND_Q12), 32'hFFFF_FF00);
		queue_elem(1022, 1022);
		queue_elem(0, 1022);
		queue_elem(1023, 0);

		// Long thin grids in both directions.
		setup_grid(MAX_SIDE, 2, CFG_DATA_W'(KIND_Q4), 7);
		queue_elem(1022, 0);
		queue_elem(511, 0);
		setup_grid(2, MAX_SIDE, CFG_DATA_W'(KIND_Q8), 0);
		queue_elem(0, 1022);

		// Grid sizes outside the legal range give no element at all.
		setup_grid(0, 5, CFG_DATA_W'(KIND_Q4), 1);
		queue_elem(0, 0);
		setup_grid(1, 1, CFG_DATA_W'(KIND_Q8), 1);
		queue_elem(0, 0);
		setup_grid(MAX_SIDE + 1, 4, CFG_DATA_W'(KIND_Q12), 1);
		queue_elem(0, 0);
		setup_grid(32'hFFFF_FFFF, 32'hFFFF_F7FF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_elem(5, 5);

		for (int p = 0; p < 14; p++)
			random_phase($urandom_range(50, 94));

		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a stuck handshake.
	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
